FILE: design/nms_pkg.sv
// shared types and codes for the navigation mode supervisor
package nms_pkg;

   typedef enum logic [3:0] {
      MODE_BOOT      = 4'd0,
      MODE_SELFCHECK = 4'd1,
      MODE_IDLE      = 4'd2,
      MODE_SURVEY    = 4'd3,
      MODE_ARCHIVE   = 4'd4,
      MODE_ENGAGE    = 4'd5,
      MODE_GOTO      = 4'd6,
      MODE_HOLD      = 4'd7,
      MODE_RECENTER  = 4'd8,
      MODE_RECOVERY  = 4'd9,
      MODE_FAILSAFE  = 4'd10
   } mode_type;

   typedef enum logic [4:0] {
      EV_NONE         = 5'd0,
      EV_SELFCHECK_OK = 5'd1,
      EV_ENTER_WARMUP = 5'd2,
      EV_ENTER_COMBAT = 5'd3,
      EV_LOAD_OK      = 5'd4,
      EV_SAVE_OK      = 5'd5,
      EV_WRITE_FAIL   = 5'd6,
      EV_VALID_FAIL   = 5'd7,
      EV_STORE_FAIL   = 5'd8,
      EV_MAP_UNAVAIL  = 5'd9,
      EV_LOC_DEGRADED = 5'd10,
      EV_PLAN_FAIL    = 5'd11,
      EV_DRIFTED      = 5'd12,
      EV_SAFETY       = 5'd13,
      EV_HEARTBEAT    = 5'd14,
      EV_REFEREE      = 5'd15,
      EV_RECOV_DONE   = 5'd16,
      EV_RECOV_ESC    = 5'd17
   } event_type;

   // flag fields of one request, time and pass-through kept outside
   typedef struct packed {
      logic       heartbeat_good;
      logic       safety_trip;
      logic       referee_update;
      logic [3:0] request_bits;
      logic [2:0] map_bits;
      logic [2:0] save_error_bits;
      logic [3:0] motion_bits;
      logic [1:0] recovery_bits;
   } flags_type;

   // decision for one request
   typedef struct packed {
      logic      mode_we;
      logic      event_we;
      mode_type  mode;
      event_type kind;
   } decision_type;

endpackage

FILE: design/nav_mode_supervisor.sv
// navigation mode supervisor top level: request register, decision, response register
// a request waits in the request register until the response register frees, then
// its response is registered; throughput: one request per cycle unless rsp_ready
// stalls; the mode decision is one level of flag logic between the request register
// and the mode and response registers; reset: synchronous, clears both stage valids,
// mode and previous mode to boot, last event to none and event time to zero
module nav_mode_supervisor
   import nms_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_heartbeat_good,
   input  logic                 req_safety_trip,
   input  logic                 req_referee_update,
   input  logic [3:0]           req_request_bits,
   input  logic [2:0]           req_map_bits,
   input  logic [2:0]           req_save_error_bits,
   input  logic [3:0]           req_motion_bits,
   input  logic [1:0]           req_recovery_bits,
   input  logic [2:0]           req_tier_in,
   input  logic [3:0]           req_action_in,
   input  logic [TIME_BITS-1:0] req_update_time,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [3:0]           rsp_mode_state,
   output logic [3:0]           rsp_earlier_state,
   output logic [4:0]           rsp_last_event_kind,
   output logic [31:0]          rsp_last_event_time,
   output logic                 rsp_mapping_on,
   output logic                 rsp_localizing_on,
   output logic                 rsp_hold_on,
   output logic                 rsp_recovering_on,
   output logic                 rsp_failsafe_on,
   output logic [2:0]           rsp_tier_out,
   output logic [3:0]           rsp_action_out
);

   // request register stage
   logic                 s1_valid_ff, s1_valid_in;
   flags_type            s1_flags_ff;
   logic [2:0]           s1_tier_ff;
   logic [3:0]           s1_action_ff;
   logic [TIME_BITS-1:0] s1_time_ff;

   // supervisor state
   mode_type             mode_ff, mode_in;
   mode_type             prev_ff, prev_in;
   event_type            kind_ff, kind_in;
   logic [TIME_BITS-1:0] etime_ff, etime_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_tier_ff;
   logic [3:0]           rsp_action_ff;

   logic                 advance;
   logic                 req_take;
   decision_type         decision;
   logic [TIME_BITS+31:0] etime_wide;

   // the response stage frees whenever it is empty or being drained
   assign advance   = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~s1_valid_ff | advance;
   assign req_take  = req_valid & req_ready;

   assign s1_valid_in  = req_take | (s1_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request payload, loaded on accept
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_flags_ff <= '{heartbeat_good:  req_heartbeat_good,
                          safety_trip:     req_safety_trip,
                          referee_update:  req_referee_update,
                          request_bits:    req_request_bits,
                          map_bits:        req_map_bits,
                          save_error_bits: req_save_error_bits,
                          motion_bits:     req_motion_bits,
                          recovery_bits:   req_recovery_bits};
         s1_tier_ff   <= req_tier_in;
         s1_action_ff <= req_action_in;
         s1_time_ff   <= req_update_time;
      end
   end

   nms_next u_next (
      .cur_mode (mode_ff),
      .flags    (s1_flags_ff),
      .decision (decision)
   );

   // state update; every transition copies the old mode, even failsafe to failsafe
   always_comb begin
      mode_in  = mode_ff;
      prev_in  = prev_ff;
      kind_in  = kind_ff;
      etime_in = etime_ff;
      if (advance && decision.mode_we) begin
         mode_in = decision.mode;
         prev_in = mode_ff;
      end
      if (advance && decision.event_we) begin
         kind_in  = decision.kind;
         etime_in = s1_time_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_BOOT;
         prev_ff  <= MODE_BOOT;
         kind_ff  <= EV_NONE;
         etime_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         prev_ff  <= prev_in;
         kind_ff  <= kind_in;
         etime_ff <= etime_in;
      end
   end

   // tier and action pass only when the new mode is recovery
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_tier_ff   <= (mode_in == MODE_RECOVERY) ? s1_tier_ff : 3'd0;
         rsp_action_ff <= (mode_in == MODE_RECOVERY) ? s1_action_ff : 4'd0;
      end
   end

   // mode and event state already hold the latest request's values, so the
   // response reads them straight from the state registers
   assign etime_wide = {32'd0, etime_ff};

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mode_state      = mode_ff;
   assign rsp_earlier_state   = prev_ff;
   assign rsp_last_event_kind = kind_ff;
   assign rsp_last_event_time = etime_wide[31:0];
   assign rsp_mapping_on      = (mode_ff == MODE_SURVEY);
   assign rsp_localizing_on   = (mode_ff == MODE_ENGAGE) || (mode_ff == MODE_GOTO) ||
                                (mode_ff == MODE_HOLD) || (mode_ff == MODE_RECENTER) ||
                                (mode_ff == MODE_RECOVERY);
   assign rsp_hold_on         = (mode_ff == MODE_HOLD);
   assign rsp_recovering_on   = (mode_ff == MODE_RECOVERY);
   assign rsp_failsafe_on     = (mode_ff == MODE_FAILSAFE);
   assign rsp_tier_out        = rsp_tier_ff;
   assign rsp_action_out      = rsp_action_ff;

`ifndef SYNTHESIS
   // heartbeat loss always lands in failsafe
   a_heartbeat_failsafe: assert property (@(posedge clock) disable iff (reset)
      (advance && !s1_flags_ff.heartbeat_good) |=> (mode_ff == MODE_FAILSAFE))
      else $error("heartbeat loss did not force failsafe");

   // state may only move when a request advances
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(mode_ff) && $stable(prev_ff) && $stable(kind_ff)))
      else $error("supervisor state changed without a request");

   // recovery pass-through only outside recovery is zero
   a_tier_gate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_tier_out != 3'd0 || rsp_action_out != 4'd0)) |->
      rsp_recovering_on)
      else $error("tier or action passed outside recovery");

   // activity groups exclude each other
   a_activity: assert property (@(posedge clock) disable iff (reset)
      $onehot0({rsp_mapping_on, rsp_localizing_on, rsp_failsafe_on}))
      else $error("conflicting activity flags");
`endif

endmodule

FILE: design/nms_next.sv
// next mode and event decision from current mode and request flags
module nms_next
   import nms_pkg::*;
(
   input  mode_type     cur_mode,
   input  flags_type    flags,
   output decision_type decision
);

   logic c_req, map_en, c_rdy, save_req;
   logic unavail, loaded, saved;
   logic wr_f, va_f, st_f;
   logic degr, plan_f, reached, drifted;
   logic exhausted, complete, ready;
   logic      go, note;
   mode_type  go_mode;
   event_type go_kind;

   assign c_req     = flags.request_bits[0];
   assign map_en    = flags.request_bits[1];
   assign c_rdy     = flags.request_bits[2];
   assign save_req  = flags.request_bits[3];
   assign unavail   = flags.map_bits[0];
   assign loaded    = flags.map_bits[1];
   assign saved     = flags.map_bits[2];
   assign wr_f      = flags.save_error_bits[0];
   assign va_f      = flags.save_error_bits[1];
   assign st_f      = flags.save_error_bits[2];
   assign degr      = flags.motion_bits[0];
   assign plan_f    = flags.motion_bits[1];
   assign reached   = flags.motion_bits[2];
   assign drifted   = flags.motion_bits[3];
   assign exhausted = flags.recovery_bits[0];
   assign complete  = flags.recovery_bits[1];
   assign ready     = c_rdy & loaded;

   always_comb begin
      go      = 1'b0;
      note    = 1'b0;
      go_mode = cur_mode;
      go_kind = EV_NONE;
      priority if (!flags.heartbeat_good) begin
         go      = 1'b1;
         go_mode = MODE_FAILSAFE;
         go_kind = EV_HEARTBEAT;
      end else if (flags.safety_trip) begin
         go      = 1'b1;
         go_mode = MODE_FAILSAFE;
         go_kind = EV_SAFETY;
      end else begin
         unique case (cur_mode)
            MODE_BOOT: begin
               go      = 1'b1;
               go_mode = MODE_SELFCHECK;
            end
            MODE_SELFCHECK: begin
               go      = 1'b1;
               go_mode = MODE_IDLE;
               go_kind = EV_SELFCHECK_OK;
            end
            MODE_IDLE: begin
               priority if (c_req && unavail) begin
                  go = 1'b1; go_mode = MODE_FAILSAFE; go_kind = EV_MAP_UNAVAIL;
               end else if (map_en) begin
                  go = 1'b1; go_mode = MODE_SURVEY; go_kind = EV_ENTER_WARMUP;
               end else if (ready) begin
                  go = 1'b1; go_mode = MODE_ENGAGE; go_kind = EV_ENTER_COMBAT;
               end else begin
                  go = 1'b0;
               end
            end
            MODE_SURVEY: begin
               if (save_req) begin
                  go = 1'b1; go_mode = MODE_ARCHIVE;
               end
            end
            MODE_ARCHIVE: begin
               // save errors only log, the mode stays put
               priority if (wr_f) begin
                  note = 1'b1; go_kind = EV_WRITE_FAIL;
               end else if (va_f) begin
                  note = 1'b1; go_kind = EV_VALID_FAIL;
               end else if (st_f) begin
                  note = 1'b1; go_kind = EV_STORE_FAIL;
               end else if (ready) begin
                  go = 1'b1; go_mode = MODE_ENGAGE; go_kind = EV_LOAD_OK;
               end else if (unavail) begin
                  go = 1'b1; go_mode = MODE_IDLE; go_kind = EV_MAP_UNAVAIL;
               end else if (saved) begin
                  go = 1'b1; go_mode = MODE_IDLE; go_kind = EV_SAVE_OK;
               end else begin
                  go = 1'b0;
               end
            end
            MODE_ENGAGE: begin
               priority if (degr) begin
                  go = 1'b1; go_mode = MODE_RECOVERY; go_kind = EV_LOC_DEGRADED;
               end else if (loaded) begin
                  go = 1'b1; go_mode = MODE_GOTO; go_kind = EV_LOAD_OK;
               end else begin
                  go = 1'b0;
               end
            end
            MODE_GOTO, MODE_RECENTER: begin
               priority if (degr) begin
                  go = 1'b1; go_mode = MODE_RECOVERY; go_kind = EV_LOC_DEGRADED;
               end else if (plan_f) begin
                  go = 1'b1; go_mode = MODE_RECOVERY; go_kind = EV_PLAN_FAIL;
               end else if (reached) begin
                  go = 1'b1; go_mode = MODE_HOLD;
               end else begin
                  go = 1'b0;
               end
            end
            MODE_HOLD: begin
               priority if (degr) begin
                  go = 1'b1; go_mode = MODE_RECOVERY; go_kind = EV_LOC_DEGRADED;
               end else if (drifted) begin
                  go = 1'b1; go_mode = MODE_RECENTER; go_kind = EV_DRIFTED;
               end else begin
                  go = 1'b0;
               end
            end
            MODE_RECOVERY: begin
               priority if (exhausted) begin
                  go = 1'b1; go_mode = MODE_FAILSAFE; go_kind = EV_RECOV_ESC;
               end else if (complete && ready) begin
                  go = 1'b1; go_mode = MODE_GOTO; go_kind = EV_RECOV_DONE;
               end else begin
                  go = 1'b0;
               end
            end
            MODE_FAILSAFE: begin
               if (!unavail) begin
                  go = 1'b1;
                  priority if (map_en) go_mode = MODE_SURVEY;
                  else if (ready)      go_mode = MODE_ENGAGE;
                  else                 go_mode = MODE_IDLE;
               end
            end
            default: begin
               go = 1'b0;
            end
         endcase
      end
   end

   // referee event is overwritten by any mode change or save error, even a mode change that records no event
   always_comb begin
      decision.mode_we  = go;
      decision.event_we = go | note | flags.referee_update;
      decision.mode     = go_mode;
      decision.kind     = (go || note) ? go_kind : EV_REFEREE;
   end

endmodule

FILE: tb/nav_mode_supervisor_scoreboard.sv
// scoreboard for the navigation mode supervisor: mode predictor and response compare
module nav_mode_supervisor_scoreboard
   import nms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_heartbeat_good,
   input  logic        req_safety_trip,
   input  logic        req_referee_update,
   input  logic [3:0]  req_request_bits,
   input  logic [2:0]  req_map_bits,
   input  logic [2:0]  req_save_error_bits,
   input  logic [3:0]  req_motion_bits,
   input  logic [1:0]  req_recovery_bits,
   input  logic [2:0]  req_tier_in,
   input  logic [3:0]  req_action_in,
   input  logic [31:0] req_update_time,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [3:0]  rsp_mode_state,
   input  logic [3:0]  rsp_earlier_state,
   input  logic [4:0]  rsp_last_event_kind,
   input  logic [31:0] rsp_last_event_time,
   input  logic        rsp_mapping_on,
   input  logic        rsp_localizing_on,
   input  logic        rsp_hold_on,
   input  logic        rsp_recovering_on,
   input  logic        rsp_failsafe_on,
   input  logic [2:0]  rsp_tier_out,
   input  logic [3:0]  rsp_action_out,
   output int          fail_count,
   output int          outstanding,
   output int          responses_checked,
   output logic [15:0] modes_seen
);

   typedef struct packed {
      mode_type    mode;
      mode_type    earlier;
      event_type   kind;
      logic [31:0] stamp;
      logic        mapping;
      logic        localizing;
      logic        holding;
      logic        recovering;
      logic        failsafe;
      logic [2:0]  tier;
      logic [3:0]  action;
   } status_type;

   // predicted supervisor state
   mode_type    mode_now;
   mode_type    mode_before;
   event_type   last_kind;
   logic [31:0] last_stamp;

   status_type  expected_status[$];

   initial begin
      fail_count        = 0;
      outstanding       = 0;
      responses_checked = 0;
      modes_seen        = '0;
   end

   task automatic report_error(input string text);
      $display("[%0t] error: %s", $realtime, text);
      fail_count++;
   endtask

   task automatic check_field(input string name, input longint got, input longint want);
      if (got != want) begin
         report_error($sformatf("response %0d field %s: got %0d, expected %0d",
                                responses_checked, name, got, want));
      end
   endtask

   function automatic void note_event(input event_type kind, input logic [31:0] stamp);
      last_kind  = kind;
      last_stamp = stamp;
   endfunction

   function automatic void move_to(input mode_type next, input event_type kind,
                                   input logic [31:0] stamp);
      mode_before = mode_now;
      mode_now    = next;
      note_event(kind, stamp);
   endfunction

   // one update through the supervisor, returns the response it should give
   task automatic advance_mode(output status_type result);
      logic        c_req, map_en, c_rdy, save_req;
      logic        unavail, loaded, saved;
      logic        wr_f, va_f, st_f;
      logic        degr, plan_f, reached, drifted;
      logic        exhausted, complete, ready;
      logic [31:0] t;
      {save_req, c_rdy, map_en, c_req} = req_request_bits;
      {saved, loaded, unavail}         = req_map_bits;
      {st_f, va_f, wr_f}               = req_save_error_bits;
      {drifted, reached, plan_f, degr} = req_motion_bits;
      {complete, exhausted}            = req_recovery_bits;
      ready = c_rdy && loaded;
      t     = req_update_time;

      if (req_referee_update) note_event(EV_REFEREE, t);

      if (!req_heartbeat_good) begin
         move_to(MODE_FAILSAFE, EV_HEARTBEAT, t);
      end else if (req_safety_trip) begin
         move_to(MODE_FAILSAFE, EV_SAFETY, t);
      end else begin
         case (mode_now)
            MODE_BOOT:      move_to(MODE_SELFCHECK, EV_NONE, t);
            MODE_SELFCHECK: move_to(MODE_IDLE, EV_SELFCHECK_OK, t);
            MODE_IDLE: begin
               if (c_req && unavail) move_to(MODE_FAILSAFE, EV_MAP_UNAVAIL, t);
               else if (map_en)      move_to(MODE_SURVEY, EV_ENTER_WARMUP, t);
               else if (ready)       move_to(MODE_ENGAGE, EV_ENTER_COMBAT, t);
            end
            MODE_SURVEY: begin
               if (save_req) move_to(MODE_ARCHIVE, EV_NONE, t);
            end
            MODE_ARCHIVE: begin
               // save errors only log, mode untouched
               if (wr_f)         note_event(EV_WRITE_FAIL, t);
               else if (va_f)    note_event(EV_VALID_FAIL, t);
               else if (st_f)    note_event(EV_STORE_FAIL, t);
               else if (ready)   move_to(MODE_ENGAGE, EV_LOAD_OK, t);
               else if (unavail) move_to(MODE_IDLE, EV_MAP_UNAVAIL, t);
               else if (saved)   move_to(MODE_IDLE, EV_SAVE_OK, t);
            end
            MODE_ENGAGE: begin
               if (degr)        move_to(MODE_RECOVERY, EV_LOC_DEGRADED, t);
               else if (loaded) move_to(MODE_GOTO, EV_LOAD_OK, t);
            end
            MODE_GOTO, MODE_RECENTER: begin
               if (degr)         move_to(MODE_RECOVERY, EV_LOC_DEGRADED, t);
               else if (plan_f)  move_to(MODE_RECOVERY, EV_PLAN_FAIL, t);
               else if (reached) move_to(MODE_HOLD, EV_NONE, t);
            end
            MODE_HOLD: begin
               if (degr)         move_to(MODE_RECOVERY, EV_LOC_DEGRADED, t);
               else if (drifted) move_to(MODE_RECENTER, EV_DRIFTED, t);
            end
            MODE_RECOVERY: begin
               if (exhausted)              move_to(MODE_FAILSAFE, EV_RECOV_ESC, t);
               else if (complete && ready) move_to(MODE_GOTO, EV_RECOV_DONE, t);
            end
            MODE_FAILSAFE: begin
               if (!unavail) begin
                  move_to(map_en ? MODE_SURVEY : (ready ? MODE_ENGAGE : MODE_IDLE),
                          EV_NONE, t);
               end
            end
            default: ;
         endcase
      end

      result.mode       = mode_now;
      result.earlier    = mode_before;
      result.kind       = last_kind;
      result.stamp      = last_stamp;
      result.mapping    = (mode_now == MODE_SURVEY);
      result.localizing = (mode_now inside {MODE_ENGAGE, MODE_GOTO, MODE_HOLD,
                                            MODE_RECENTER, MODE_RECOVERY});
      result.holding    = (mode_now == MODE_HOLD);
      result.recovering = (mode_now == MODE_RECOVERY);
      result.failsafe   = (mode_now == MODE_FAILSAFE);
      result.tier       = result.recovering ? req_tier_in : 3'd0;
      result.action     = result.recovering ? req_action_in : 4'd0;
   endtask

   always @(posedge clock) begin
      status_type want;
      if (reset) begin
         mode_now    = MODE_BOOT;
         mode_before = MODE_BOOT;
         last_kind   = EV_NONE;
         last_stamp  = '0;
         expected_status.delete();
      end else begin
         if (req_valid && req_ready) begin
            advance_mode(want);
            expected_status.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_status.size() == 0) begin
               report_error($sformatf("response with mode %0d arrived with none pending",
                                      rsp_mode_state));
            end else begin
               want = expected_status.pop_front();
               check_field("mode_state", longint'(rsp_mode_state), longint'(want.mode));
               check_field("earlier_state", longint'(rsp_earlier_state),
                           longint'(want.earlier));
               check_field("last_event_kind", longint'(rsp_last_event_kind),
                           longint'(want.kind));
               check_field("last_event_time", longint'(rsp_last_event_time),
                           longint'(want.stamp));
               check_field("mapping_on", longint'(rsp_mapping_on), longint'(want.mapping));
               check_field("localizing_on", longint'(rsp_localizing_on),
                           longint'(want.localizing));
               check_field("hold_on", longint'(rsp_hold_on), longint'(want.holding));
               check_field("recovering_on", longint'(rsp_recovering_on),
                           longint'(want.recovering));
               check_field("failsafe_on", longint'(rsp_failsafe_on), longint'(want.failsafe));
               check_field("tier_out", longint'(rsp_tier_out), longint'(want.tier));
               check_field("action_out", longint'(rsp_action_out), longint'(want.action));
            end
            modes_seen[rsp_mode_state] = 1'b1;
            responses_checked++;
         end
      end
      outstanding = expected_status.size();
   end

endmodule

FILE: tb/nav_mode_supervisor_test.sv
// top-level testbench for the navigation mode supervisor: clock, reset, stimulus, verdict
module nav_mode_supervisor_test;

   // cycles with no request or response accepted before the run is called hung
   localparam int QUIET_LIMIT  = 2000;
   localparam int RANDOM_COUNT = 900;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid;
   logic        req_ready;
   logic        req_heartbeat_good;
   logic        req_safety_trip;
   logic        req_referee_update;
   logic [3:0]  req_request_bits;
   logic [2:0]  req_map_bits;
   logic [2:0]  req_save_error_bits;
   logic [3:0]  req_motion_bits;
   logic [1:0]  req_recovery_bits;
   logic [2:0]  req_tier_in;
   logic [3:0]  req_action_in;
   logic [31:0] req_update_time;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [3:0]  rsp_mode_state;
   logic [3:0]  rsp_earlier_state;
   logic [4:0]  rsp_last_event_kind;
   logic [31:0] rsp_last_event_time;
   logic        rsp_mapping_on;
   logic        rsp_localizing_on;
   logic        rsp_hold_on;
   logic        rsp_recovering_on;
   logic        rsp_failsafe_on;
   logic [2:0]  rsp_tier_out;
   logic [3:0]  rsp_action_out;

   int          fail_count;
   int          outstanding;
   int          responses_checked;
   logic [15:0] modes_seen;

   // when set, neither side inserts idle cycles
   logic        no_idle = 1'b0;
   int          requests_sent = 0;
   int          quiet_cycles = 0;

   nav_mode_supervisor dut (.*);

   nav_mode_supervisor_scoreboard mode_check (.*);

   always #4 clock = ~clock;

   // hang detection: counts cycles in which neither channel moves
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", quiet_cycles);
            $display("FAIL nav_mode_supervisor");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // response side: random stalls per response, one long stall to back up the pipe
   initial begin
      int hold_off;
      int accepted;
      accepted  = 0;
      rsp_ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         hold_off = no_idle ? 0 : $urandom_range(0, 4);
         // long stall while the sender keeps offering, so req_ready must drop
         if (accepted == 300) hold_off = 60;
         if (hold_off > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         accepted++;
      end
   end

   // offer one request after a random gap and hold it until accepted
   task automatic send_update(input logic hb, input logic trip, input logic referee,
                              input logic [3:0] rq, input logic [2:0] mp,
                              input logic [2:0] se, input logic [3:0] mo,
                              input logic [1:0] rc, input logic [2:0] tier,
                              input logic [3:0] act, input logic [31:0] stamp);
      int gap;
      @(negedge clock);
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_heartbeat_good  <= hb;
      req_safety_trip     <= trip;
      req_referee_update  <= referee;
      req_request_bits    <= rq;
      req_map_bits        <= mp;
      req_save_error_bits <= se;
      req_motion_bits     <= mo;
      req_recovery_bits   <= rc;
      req_tier_in         <= tier;
      req_action_in       <= act;
      req_update_time     <= stamp;
      req_valid           <= 1'b1;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   // stop offering and wait for every pending response
   task automatic drain_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // mostly healthy updates so the mode machine walks deep into its states
   task automatic send_random();
      logic [3:0]  mo;
      logic [2:0]  mp;
      logic [2:0]  se;
      logic [1:0]  rc;
      logic [31:0] stamp;
      mo = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 3) != 0) mo[0] = 1'b0;     // keep degraded localization rare
      mp = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 2) != 0) mp[0] = 1'b0;     // map mostly available
      se = ($urandom_range(0, 1) != 0) ? 3'd0 : 3'($urandom_range(0, 7));
      rc = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 2) != 0) rc[0] = 1'b0;     // recovery rarely exhausted
      case ($urandom_range(0, 7))
         0:       stamp = 32'd0;
         1:       stamp = 32'hFFFF_FFFF;
         default: stamp = $urandom;
      endcase
      send_update($urandom_range(0, 15) != 0, $urandom_range(0, 15) == 0,
                  $urandom_range(0, 7) == 0, 4'($urandom_range(0, 15)), mp, se, mo, rc,
                  3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), stamp);
   endtask

   initial begin
      int directed_count;
      req_valid           = 1'b0;
      req_heartbeat_good  = 1'b1;
      req_safety_trip     = 1'b0;
      req_referee_update  = 1'b0;
      req_request_bits    = '0;
      req_map_bits        = '0;
      req_save_error_bits = '0;
      req_motion_bits     = '0;
      req_recovery_bits   = '0;
      req_tier_in         = '0;
      req_action_in       = '0;
      req_update_time     = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed walk: every mode, every event, field extremes
      // boot to selfcheck, then selfcheck ok overrides the referee event
      send_update(1'b1, 1'b0, 1'b0, 4'b0000, 3'b000, 3'b000, 4'b0000, 2'b00, 3'd0, 4'd0, 32'd0);
      send_update(1'b1, 1'b0, 1'b1, 4'b0000, 3'b000, 3'b000, 4'b0000, 2'b00, 3'd0, 4'd0,
                  32'hFFFF_FFFF);
      // combat asked with no map goes to failsafe
      send_update(1'b1, 1'b0, 1'b0, 4'b0001, 3'b001, 3'b000, 4'b0000, 2'b00, 3'd0, 4'd0, 32'd1);
      // failsafe held by missing map, referee event alone, tier and action masked
      send_update(1'b1, 1'b0, 1'b1, 4'b0000, 3'b001, 3'b000, 4'b0000, 2'b00, 3'd7, 4'd15,
                  32'd2);
      send_update(1'b1, 1'b0, 1'b0, 4'b0000, 3'b000, 3'b000, 4'b0000, 2'b00, 3'd0, 4'd0, 32'd3);
      // idle to warmup to save, then each save error in priority order
      send_update(1'b1, 1'b0, 1'b0, 4'b0010, 3'b000, 3'b000, 4'b0000, 2'b00, 3'd0, 4'd0, 32'd4);
      send_update(1'b1, 1'b0, 1'b0, 4'b1000, 3'b000, 3'b000, 4'b0000, 2'b00, 3'd0, 4'd0, 32'd5);
      send_update(1'b1, 1'b0, 1'b0, 4'b0000, 3'b000, 3'b001, 4'b0000, 2'b00, 3'd0, 4'd0, 32'd6);
      send_update(1'b1, 1'b0, 1'b0, 4'b0000, 3'b000, 3'b010, 4'b0000, 2'b00, 3'd0, 4'd0, 32'd7);
      send_update(1'b1, 1'b0, 1'b0, 4'b0000, 3'b000, 3'b100, 4'b0000, 2'b00, 3'd0, 4'd0, 32'd8);
      // save abandoned on missing map
      send_update(1'b1, 1'b0, 1'b0, 4'b0000, 3'b001, 3'b000, 4'b0000, 2'b00, 3'd0, 4'd0, 32'd9);
      send_update(1'b1, 1'b0, 1'b0, 4'b0010, 3'b000, 3'b000, 4'b0000, 2'b00, 3'd0, 4'd0,
                  32'd10);
      send_update(1'b1, 1'b0, 1'b0, 4'b1000, 3'b000, 3'b000, 4'b0000, 2'b00, 3'd0, 4'd0,
                  32'd11);
      // save completes back to idle, then straight into combat
      send_update(1'b1, 1'b0, 1'b0, 4'b0000, 3'b100, 3'b000, 4'b0000, 2'b00, 3'd0, 4'd0,
                  32'd12);
      send_update(1'b1, 1'b0, 1'b0, 4'b0100, 3'b010, 3'b000, 4'b0000, 2'b00, 3'd0, 4'd0,
                  32'd13);
      // combat, goto, hold, recenter, then planner failure into recovery
      send_update(1'b1, 1'b0, 1'b0, 4'b0000, 3'b010, 3'b000, 4'b0000, 2'b00, 3'd0, 4'd0,
                  32'd14);
      send_update(1'b1, 1'b0, 1'b0, 4'b0000, 3'b000, 3'b000, 4'b0100, 2'b00, 3'd0, 4'd0,
                  32'd15);
      send_update(1'b1, 1'b0, 1'b0, 4'b0000, 3'b000, 3'b000, 4'b1000, 2'b00, 3'd0, 4'd0,
                  32'd16);
      send_update(1'b1, 1'b0, 1'b0, 4'b0000, 3'b000, 3'b000, 4'b0010, 2'b00, 3'd7, 4'd15,
                  32'd17);
      // recovery complete with combat ready returns to goto
      send_update(1'b1, 1'b0, 1'b0, 4'b0100, 3'b010, 3'b000, 4'b0000, 2'b10, 3'd7, 4'd15,
                  32'd18);
      send_update(1'b1, 1'b0, 1'b0, 4'b0000, 3'b000, 3'b000, 4'b0001, 2'b00, 3'd3, 4'd9,
                  32'd19);
      // recovery exhausted escalates to failsafe, failsafe exits to combat
      send_update(1'b1, 1'b0, 1'b0, 4'b0000, 3'b000, 3'b000, 4'b0000, 2'b01, 3'd5, 4'd6,
                  32'd20);
      send_update(1'b1, 1'b0, 1'b0, 4'b0100, 3'b010, 3'b000, 4'b0000, 2'b00, 3'd0, 4'd0,
                  32'd21);
      send_update(1'b1, 1'b0, 1'b0, 4'b0000, 3'b000, 3'b000, 4'b0001, 2'b00, 3'd1, 4'd1,
                  32'd22);
      // safety trip from recovery, then heartbeat loss while already in failsafe
      send_update(1'b1, 1'b1, 1'b0, 4'b0000, 3'b000, 3'b000, 4'b0000, 2'b00, 3'd7, 4'd15,
                  32'd23);
      send_update(1'b0, 1'b1, 1'b1, 4'b1111, 3'b111, 3'b111, 4'b1111, 2'b11, 3'd7, 4'd15,
                  32'hFFFF_FFFF);
      // failsafe exits to warmup when mapping is enabled
      send_update(1'b1, 1'b0, 1'b0, 4'b0010, 3'b000, 3'b000, 4'b0000, 2'b00, 3'd0, 4'd0,
                  32'd25);
      directed_count = requests_sent;

      for (int n = 0; n < RANDOM_COUNT; n++) begin
         // a stretch with no idle cycles on either side
         no_idle = (n >= 450 && n < 550);
         // one full drain mid-run
         if (n == 700) drain_pipeline();
         send_random();
      end

      drain_pipeline();
      repeat (4) @(negedge clock);

      $display("sent %0d requests (%0d directed), checked %0d responses",
               requests_sent, directed_count, responses_checked);
      $display("reached %0d of 11 modes, with a long output stall and a full drain",
               $countones(modes_seen));
      if (fail_count == 0) begin
         $display("PASS nav_mode_supervisor");
      end else begin
         $display("FAIL nav_mode_supervisor");
      end
      $finish;
   end

endmodule
